/* sv/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs sampler package
// Shared constants, default parameter values, and the command and status
// types that pass between the sampler controller and its datapath.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int DEF_NUM_TOPICS  = 16;
  localparam int DEF_MAX_VOCAB   = 4096;
  localparam int DEF_MAX_DOCS    = 1024;
  localparam int DEF_MAX_TOKENS  = 65536;
  localparam int DEF_COUNT_WIDTH = 20;

  localparam int TOK_W   = 16;
  localparam int WORD_W  = 12;
  localparam int DOC_W   = 10;
  localparam int ITOP_W  = 4;
  localparam int UNI_W   = 32;
  localparam int TOPIC_W = 4;
  localparam int PRIOR_W = 24;
  localparam int VOCAB_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int WEIGHT_W  = 64;
  localparam int FRAC_W    = 16;

  localparam int STEP_W    = 6;
  localparam int RED_STEPS = 16;
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_VOCAB = 2'd2
  } lgs_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_REDUCE,
    OP_TOK_RD,
    OP_OLD_RD,
    OP_DEC,
    OP_W_RD,
    OP_OPND,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_ACC,
    OP_THR_HI,
    OP_THR_LO,
    OP_THR_SUM,
    OP_CW_RD,
    OP_CMP,
    OP_ADD_RD,
    OP_INC
  } lgs_op_t;

  typedef struct packed {
    lgs_op_t           op;
    logic [STEP_W-1:0] step;
  } lgs_cmd_t;

  typedef struct packed {
    logic kind;
    logic hit;
    logic clr_last;
  } lgs_stat_t;

endpackage

/* sv/lgs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write when enabled, registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/lgs_ctrl.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs sampler controller
// Sequences the clearing pass, count updates, the per-topic weight loop,
// the threshold and the topic search, and issues one command per cycle.
// ----------------------------------------------------------------------------
module lgs_ctrl #(
  parameter int NUM_TOPICS = lgs_pkg::DEF_NUM_TOPICS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  lgs_pkg::lgs_stat_t            st,
  output lgs_pkg::lgs_cmd_t             cmd,
  output logic [$clog2(NUM_TOPICS)-1:0] k,
  output logic                          busy
);
  import lgs_pkg::*;

  localparam int TW = $clog2(NUM_TOPICS);
  localparam logic [TW-1:0] K_LAST = TW'(NUM_TOPICS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_TOK_RD, S_OLD_RD, S_DEC, S_W_RD, S_OPND,
    S_MUL, S_DIV_INIT, S_DIV, S_ACC, S_THR_HI, S_THR_LO, S_THR_SUM,
    S_CW_RD, S_CMP, S_ADD_RD, S_INC
  } state_t;

  state_t            state, state_next;
  logic [TW-1:0]     k_next;
  logic [STEP_W-1:0] step_next;
  lgs_op_t           op_next;

  always_comb begin
    state_next = state;
    k_next     = k;
    step_next  = cmd.step;
    unique case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_REDUCE;
          step_next  = STEP_W'(RED_STEPS - 1);
        end
      end
      S_REDUCE: begin
        if (cmd.step == '0) begin
          state_next = st.kind ? S_TOK_RD : S_ADD_RD;
        end else begin
          step_next = cmd.step - 1'b1;
        end
      end
      S_TOK_RD: state_next = S_OLD_RD;
      S_OLD_RD: state_next = S_DEC;
      S_DEC: begin
        state_next = S_W_RD;
        k_next     = '0;
      end
      S_W_RD: state_next = S_OPND;
      S_OPND: begin
        state_next = S_MUL;
        step_next  = '0;
      end
      S_MUL: begin
        if (cmd.step == STEP_W'(MUL_STEPS - 1)) begin
          state_next = S_DIV_INIT;
        end else begin
          step_next = cmd.step + 1'b1;
        end
      end
      S_DIV_INIT: begin
        state_next = S_DIV;
        step_next  = STEP_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        if (cmd.step == '0) begin
          state_next = S_ACC;
        end else begin
          step_next = cmd.step - 1'b1;
        end
      end
      S_ACC: begin
        if (k == K_LAST) begin
          state_next = S_THR_HI;
        end else begin
          state_next = S_W_RD;
          k_next     = k + 1'b1;
        end
      end
      S_THR_HI: state_next = S_THR_LO;
      S_THR_LO: state_next = S_THR_SUM;
      S_THR_SUM: begin
        state_next = S_CW_RD;
        k_next     = '0;
      end
      S_CW_RD: state_next = S_CMP;
      S_CMP: begin
        if (st.hit || k == K_LAST) begin
          state_next = S_ADD_RD;
        end else begin
          state_next = S_CW_RD;
          k_next     = k + 1'b1;
        end
      end
      S_ADD_RD: state_next = S_INC;
      S_INC:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase

    unique case (state_next)
      S_CLEAR:    op_next = OP_CLEAR;
      S_IDLE:     op_next = OP_NONE;
      S_REDUCE:   op_next = OP_REDUCE;
      S_TOK_RD:   op_next = OP_TOK_RD;
      S_OLD_RD:   op_next = OP_OLD_RD;
      S_DEC:      op_next = OP_DEC;
      S_W_RD:     op_next = OP_W_RD;
      S_OPND:     op_next = OP_OPND;
      S_MUL:      op_next = OP_MUL;
      S_DIV_INIT: op_next = OP_DIV_INIT;
      S_DIV:      op_next = OP_DIV;
      S_ACC:      op_next = OP_ACC;
      S_THR_HI:   op_next = OP_THR_HI;
      S_THR_LO:   op_next = OP_THR_LO;
      S_THR_SUM:  op_next = OP_THR_SUM;
      S_CW_RD:    op_next = OP_CW_RD;
      S_CMP:      op_next = OP_CMP;
      S_ADD_RD:   op_next = OP_ADD_RD;
      S_INC:      op_next = OP_INC;
      default:    op_next = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cmd.op   <= OP_CLEAR;
      cmd.step <= '0;
      k        <= '0;
      busy     <= 1'b1;
    end else begin
      state    <= state_next;
      cmd.op   <= op_next;
      cmd.step <= step_next;
      k        <= k_next;
      busy     <= (state_next != S_IDLE);
    end
  end

endmodule

/* sv/lgs_dp.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs sampler datapath
// Count memories, token topic memory, weight arithmetic with a split
// multiplier and a bit-serial divider, cumulative weights and the search.
// ----------------------------------------------------------------------------
module lgs_dp #(
  parameter int NUM_TOPICS  = lgs_pkg::DEF_NUM_TOPICS,
  parameter int MAX_VOCAB   = lgs_pkg::DEF_MAX_VOCAB,
  parameter int MAX_DOCS    = lgs_pkg::DEF_MAX_DOCS,
  parameter int MAX_TOKENS  = lgs_pkg::DEF_MAX_TOKENS,
  parameter int COUNT_WIDTH = lgs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            kind,
  input  logic [lgs_pkg::TOK_W-1:0]       token_index,
  input  logic [lgs_pkg::WORD_W-1:0]      word_index,
  input  logic [lgs_pkg::DOC_W-1:0]       doc_index,
  input  logic [lgs_pkg::ITOP_W-1:0]      init_topic,
  input  logic [lgs_pkg::UNI_W-1:0]       uniform_draw,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgs_pkg::PRIOR_W-1:0]     cfg_data,
  input  lgs_pkg::lgs_cmd_t               cmd,
  input  logic [$clog2(NUM_TOPICS)-1:0]   k,
  output lgs_pkg::lgs_stat_t              st,
  output logic                            done,
  output logic [lgs_pkg::TOK_W-1:0]       token_index_out,
  output logic [lgs_pkg::TOPIC_W-1:0]     topic
);
  import lgs_pkg::*;

  localparam int TW   = $clog2(NUM_TOPICS);
  localparam int VW   = $clog2(MAX_VOCAB);
  localparam int DW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int KW   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int WAW  = VW + TW;
  localparam int DAW  = DW + TW;
  localparam int WC_DEPTH = 2 ** WAW;
  localparam int DC_DEPTH = 2 ** DAW;
  localparam int TT_DEPTH = 2 ** TW;
  localparam int TK_DEPTH = 2 ** KW;
  localparam int CLR_W = (WAW > DAW) ? WAW : DAW;
  localparam int OPW  = COUNT_WIDTH + FRAC_W + 1;
  localparam int HW   = (OPW + 1) / 2;
  localparam int PW   = 4 * HW;
  localparam int VBW  = VOCAB_W + PRIOR_W;
  localparam int DNW  = ((COUNT_WIDTH + FRAC_W > VBW) ? COUNT_WIDTH + FRAC_W : VBW) + 1;
  localparam int PHW  = PW - 3 * FRAC_W;
  localparam int CMPW = (PHW > DNW) ? PHW : DNW;

  logic [PRIOR_W-1:0]  alpha, beta;
  logic [VOCAB_W-1:0]  vocab;
  logic                kind_r;
  logic [TOK_W-1:0]    tok_raw, tok_r, tok_red;
  logic [WORD_W-1:0]   w_r, w_red;
  logic [DOC_W-1:0]    d_r, d_red;
  logic [ITOP_W-1:0]   t_r, t_red;
  logic [UNI_W-1:0]    u_r;
  logic [VBW-1:0]      vb;
  logic [TW-1:0]       old_t, new_t, tsel;
  logic [OPW-1:0]      a_op, b_op;
  logic [DNW-1:0]      den, rem;
  logic [PW-1:0]       prod, pp;
  logic [HW-1:0]       pa, pb;
  logic [2*HW-1:0]     a_ext, b_ext, pprod;
  logic [DNW:0]        trial;
  logic [WEIGHT_W-1:0] nlo, quo, sum, sum_next, wt, phi, plo, thr;
  logic                sat, dzero;
  logic [CLR_W-1:0]    clr_addr;
  logic [3:0]          rs;
  logic                clr;

  logic [WAW-1:0]         wc_addr;
  logic [DAW-1:0]         dc_addr;
  logic                   wc_we, dc_we, tt_we, tk_we, cw_we;
  logic [COUNT_WIDTH-1:0] wc_q, dc_q, tt_q, wc_wd, dc_wd, tt_wd;
  logic [TW-1:0]          tk_q;
  logic [WEIGHT_W-1:0]    cw_q;

  assign cfg_ready = 1'b1;
  assign clr       = (cmd.op == OP_CLEAR);
  assign rs        = cmd.step[3:0];

  always_comb begin
    tok_red = (64'(tok_r) >= (64'(MAX_TOKENS) << rs)) ?
              tok_r - TOK_W'(64'(MAX_TOKENS) << rs) : tok_r;
    w_red   = (64'(w_r) >= (64'(MAX_VOCAB) << rs)) ?
              w_r - WORD_W'(64'(MAX_VOCAB) << rs) : w_r;
    d_red   = (64'(d_r) >= (64'(MAX_DOCS) << rs)) ?
              d_r - DOC_W'(64'(MAX_DOCS) << rs) : d_r;
    t_red   = (64'(t_r) >= (64'(NUM_TOPICS) << rs)) ?
              t_r - ITOP_W'(64'(NUM_TOPICS) << rs) : t_r;
  end

  always_comb begin
    case (cmd.op) inside
      OP_OLD_RD:         tsel = tk_q;
      OP_DEC:            tsel = old_t;
      OP_ADD_RD, OP_INC: tsel = new_t;
      default:           tsel = k;
    endcase
  end

  assign wc_addr = clr ? WAW'(clr_addr) : {VW'(w_r), tsel};
  assign dc_addr = clr ? DAW'(clr_addr) : {DW'(d_r), tsel};
  assign wc_we   = clr || cmd.op == OP_DEC || cmd.op == OP_INC;
  assign dc_we   = (clr && int'(clr_addr) < DC_DEPTH) || cmd.op == OP_DEC || cmd.op == OP_INC;
  assign tt_we   = (clr && int'(clr_addr) < TT_DEPTH) || cmd.op == OP_DEC || cmd.op == OP_INC;
  assign tk_we   = (cmd.op == OP_ADD_RD);
  assign cw_we   = (cmd.op == OP_ACC);

  always_comb begin
    if (clr) begin
      wc_wd = '0;
      dc_wd = '0;
      tt_wd = '0;
    end else if (cmd.op == OP_DEC) begin
      wc_wd = (wc_q == '0) ? '0 : wc_q - 1'b1;
      dc_wd = (dc_q == '0) ? '0 : dc_q - 1'b1;
      tt_wd = (tt_q == '0) ? '0 : tt_q - 1'b1;
    end else begin
      wc_wd = (wc_q == '1) ? wc_q : wc_q + 1'b1;
      dc_wd = (dc_q == '1) ? dc_q : dc_q + 1'b1;
      tt_wd = (tt_q == '1) ? tt_q : tt_q + 1'b1;
    end
  end

  lgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(WC_DEPTH)) u_wc (
    .clk(clk), .we(wc_we), .addr(wc_addr), .wdata(wc_wd), .rdata(wc_q)
  );
  lgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DC_DEPTH)) u_dc (
    .clk(clk), .we(dc_we), .addr(dc_addr), .wdata(dc_wd), .rdata(dc_q)
  );
  lgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TT_DEPTH)) u_tt (
    .clk(clk), .we(tt_we), .addr(clr ? TW'(clr_addr) : tsel), .wdata(tt_wd), .rdata(tt_q)
  );
  lgs_ram #(.WIDTH(TW), .DEPTH(TK_DEPTH)) u_tk (
    .clk(clk), .we(tk_we), .addr(KW'(tok_r)), .wdata(new_t), .rdata(tk_q)
  );
  lgs_ram #(.WIDTH(WEIGHT_W), .DEPTH(TT_DEPTH)) u_cw (
    .clk(clk), .we(cw_we), .addr(k), .wdata(sum_next), .rdata(cw_q)
  );

  always_comb begin
    a_ext = (2*HW)'(a_op);
    b_ext = (2*HW)'(b_op);
    pa    = cmd.step[1] ? a_ext[2*HW-1:HW] : a_ext[HW-1:0];
    pb    = cmd.step[0] ? b_ext[2*HW-1:HW] : b_ext[HW-1:0];
    pprod = pa * pb;
    case (cmd.step[1:0])
      2'd0:    pp = PW'(pprod);
      2'd3:    pp = PW'(pprod) << (2 * HW);
      default: pp = PW'(pprod) << HW;
    endcase
  end

  assign trial    = {rem, nlo[WEIGHT_W-1]};
  assign wt       = dzero ? '0 : (sat ? '1 : quo);
  assign sum_next = (sum > ~wt) ? '1 : sum + wt;

  assign st.kind     = kind_r;
  assign st.hit      = (cw_q > thr);
  assign st.clr_last = (clr_addr == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= PRIOR_W'(65536);
      beta     <= PRIOR_W'(6554);
      vocab    <= VOCAB_W'(4096);
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ALPHA: alpha <= cfg_data;
          CFG_BETA:  beta  <= cfg_data;
          CFG_VOCAB: vocab <= cfg_data[VOCAB_W-1:0];
          default:   ;
        endcase
      end
      if (clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      done <= (cmd.op == OP_INC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind;
      tok_raw <= token_index;
      tok_r   <= token_index;
      w_r     <= word_index;
      d_r     <= doc_index;
      t_r     <= init_topic;
      u_r     <= uniform_draw;
      vb      <= VBW'(vocab) * VBW'(beta);
    end
    if (cmd.op == OP_INC) begin
      token_index_out <= tok_raw;
      topic           <= TOPIC_W'(new_t);
    end
    case (cmd.op)
      OP_REDUCE: begin
        tok_r <= tok_red;
        w_r   <= w_red;
        d_r   <= d_red;
        t_r   <= t_red;
        new_t <= TW'(t_red);
      end
      OP_OLD_RD: old_t <= tk_q;
      OP_DEC:    sum   <= '0;
      OP_OPND: begin
        a_op <= OPW'({wc_q, 16'h0000}) + OPW'(beta);
        b_op <= OPW'({dc_q, 16'h0000}) + OPW'(alpha);
        den  <= DNW'({tt_q, 16'h0000}) + DNW'(vb);
        prod <= '0;
      end
      OP_MUL: prod <= prod + pp;
      OP_DIV_INIT: begin
        rem   <= DNW'(prod[PW-1:3*FRAC_W]);
        nlo   <= {prod[3*FRAC_W-1:0], 16'h0000};
        sat   <= CMPW'(prod[PW-1:3*FRAC_W]) >= CMPW'(den);
        dzero <= (den == '0);
        quo   <= '0;
      end
      OP_DIV: begin
        nlo <= nlo << 1;
        if (trial >= {1'b0, den}) begin
          rem <= DNW'(trial - {1'b0, den});
          quo <= {quo[WEIGHT_W-2:0], 1'b1};
        end else begin
          rem <= DNW'(trial);
          quo <= {quo[WEIGHT_W-2:0], 1'b0};
        end
      end
      OP_ACC:     sum <= sum_next;
      OP_THR_HI:  phi <= 64'(sum[63:32]) * 64'(u_r);
      OP_THR_LO:  plo <= 64'(sum[31:0]) * 64'(u_r);
      OP_THR_SUM: thr <= phi + {32'h0, plo[63:32]};
      OP_CMP:     new_t <= k;
      default:    ;
    endcase
  end

endmodule

/* sv/lda_gibbs_topic_sampler.sv */
// ----------------------------------------------------------------------------
// LDA collapsed Gibbs topic sampler
// Keeps word-topic, document-topic and topic-total counts plus one topic per
// token, adds tokens at init and resamples their topic from the counts.
//
//   Channel  Signals                                      Beat
//   input    start, busy, kind, token_index, word_index,  start && !busy
//            doc_index, init_topic, uniform_draw
//   result   done, token_index_out, topic                 done (one cycle)
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// After reset a clearing pass walks every address of the count memories
// and zeroes them; busy stays high throughout. A resample item runs the
// 64-step serial divider once per topic, then searches the topics in order.
// One item is in flight at a time; results cannot be stalled.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_sampler #(
  parameter int NUM_TOPICS  = lgs_pkg::DEF_NUM_TOPICS,
  parameter int MAX_VOCAB   = lgs_pkg::DEF_MAX_VOCAB,
  parameter int MAX_DOCS    = lgs_pkg::DEF_MAX_DOCS,
  parameter int MAX_TOKENS  = lgs_pkg::DEF_MAX_TOKENS,
  parameter int COUNT_WIDTH = lgs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [lgs_pkg::TOK_W-1:0]     token_index,
  input  logic [lgs_pkg::WORD_W-1:0]    word_index,
  input  logic [lgs_pkg::DOC_W-1:0]     doc_index,
  input  logic [lgs_pkg::ITOP_W-1:0]    init_topic,
  input  logic [lgs_pkg::UNI_W-1:0]     uniform_draw,
  output logic                          done,
  output logic [lgs_pkg::TOK_W-1:0]     token_index_out,
  output logic [lgs_pkg::TOPIC_W-1:0]   topic,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::PRIOR_W-1:0]   cfg_data
);
  import lgs_pkg::*;

  localparam int TW = $clog2(NUM_TOPICS);

  logic          accept;
  lgs_cmd_t      cmd;
  lgs_stat_t     st;
  logic [TW-1:0] k;

  assign accept = start && !busy;

  lgs_ctrl #(.NUM_TOPICS(NUM_TOPICS)) u_ctrl (
    .clk(clk), .rst(rst), .accept(accept), .st(st), .cmd(cmd), .k(k), .busy(busy)
  );

  lgs_dp #(
    .NUM_TOPICS(NUM_TOPICS), .MAX_VOCAB(MAX_VOCAB), .MAX_DOCS(MAX_DOCS),
    .MAX_TOKENS(MAX_TOKENS), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .accept(accept), .kind(kind), .token_index(token_index),
    .word_index(word_index), .doc_index(doc_index), .init_topic(init_topic),
    .uniform_draw(uniform_draw), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .k(k), .st(st),
    .done(done), .token_index_out(token_index_out), .topic(topic)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a preceding busy cycle.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Two result beats in consecutive cycles.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Block not busy after accepting an item.");

endmodule
